/* design/lsbp_pkg.sv */
// ---------------------------------------------------------------------------
// lsbp_pkg: shared types and constants of the LSB-first bit packer
// Item kinds, datapath command and status groups, and datapath widths.
// ---------------------------------------------------------------------------
`default_nettype none

package lsbp_pkg;

   // Bits in one output byte.
   localparam int BYTE_BITS = 8;

   // Width of an appended code and of its bit count.
   localparam int CODE_BITS  = 32;
   localparam int COUNT_BITS = 6;

   // Accumulator: a partial byte of up to seven bits plus one full code.
   localparam int ACC_BITS = BYTE_BITS + CODE_BITS;

   // Bytes still to send for one item, 0 to 4.
   localparam int BYTES_BITS = 3;

   // Item kinds, carried on the request tuser bit.
   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_write;  // merge the request code into the accumulator
      logic load_flush;  // queue the partial byte for output and clear the fill
      logic shift_byte;  // the current output byte was taken
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic write_has_bytes;  // the request code completes at least one byte
      logic fill_zero;        // no bits are held in the partial byte
      logic last_byte;        // the byte on the output is the last of the item
   } dp_status_type;

endpackage : lsbp_pkg

`default_nettype wire

/* design/lsbp_datapath.sv */
// ---------------------------------------------------------------------------
// lsbp_datapath: accumulator and byte counter of the bit packer
// Merges codes above the held bits; shifts completed bytes out, one a cycle when taken.
// ---------------------------------------------------------------------------
`default_nettype none

module lsbp_datapath #(
   parameter int MAX_CODE_BITS = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  lsbp_pkg::dp_cmd_type         cmd,
   output lsbp_pkg::dp_status_type      status,
   input  wire [lsbp_pkg::CODE_BITS-1:0]  code_value,
   input  wire [lsbp_pkg::COUNT_BITS-1:0] bit_count,
   output logic [lsbp_pkg::BYTE_BITS-1:0] out_byte
);
   import lsbp_pkg::*;

   // Largest number of bits that one code may append.
   localparam int LIMIT = (MAX_CODE_BITS < CODE_BITS) ? MAX_CODE_BITS : CODE_BITS;

   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [2:0]            fill_ff, fill_in;
   logic [BYTES_BITS-1:0] bytes_ff, bytes_in;

   logic [COUNT_BITS-1:0] eff_count;
   logic [CODE_BITS-1:0]  masked_code;
   logic [ACC_BITS-1:0]   merged;
   logic [COUNT_BITS-1:0] total;
   logic [BYTES_BITS-1:0] total_bytes;

   // Saturate the bit count, drop unused code bits and place the code above
   // the bits already held. Bits above the fill are zero whenever a code is merged.
   always_comb begin
      eff_count   = (bit_count > COUNT_BITS'(LIMIT)) ? COUNT_BITS'(LIMIT) : bit_count;
      masked_code = code_value & ~({CODE_BITS{1'b1}} << eff_count);
      merged      = acc_ff | (ACC_BITS'(masked_code) << fill_ff);
      total       = COUNT_BITS'(fill_ff) + eff_count;
      total_bytes = BYTES_BITS'(total >> 3);
   end

   // Next state of the accumulator, fill and pending byte count.
   always_comb begin
      acc_in   = acc_ff;
      fill_in  = fill_ff;
      bytes_in = bytes_ff;
      if (cmd.load_write) begin
         acc_in   = merged;
         fill_in  = total[2:0];
         bytes_in = total_bytes;
      end else if (cmd.load_flush) begin
         fill_in  = 3'd0;
         bytes_in = BYTES_BITS'(1);
      end else if (cmd.shift_byte) begin
         acc_in   = acc_ff >> BYTE_BITS;
         bytes_in = bytes_ff - BYTES_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         fill_ff  <= 3'd0;
         bytes_ff <= '0;
      end else begin
         acc_ff   <= acc_in;
         fill_ff  <= fill_in;
         bytes_ff <= bytes_in;
      end
   end

   // Status and output byte.
   always_comb begin
      status.write_has_bytes = (total_bytes != '0);
      status.fill_zero       = (fill_ff == 3'd0);
      status.last_byte       = (bytes_ff == BYTES_BITS'(1));
      out_byte               = acc_ff[BYTE_BITS-1:0];
   end

endmodule : lsbp_datapath

`default_nettype wire

/* design/lsbp_ctrl.sv */
// ---------------------------------------------------------------------------
// lsbp_ctrl: controller of the bit packer
// Accepts one item at a time and steps its bytes out over the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module lsbp_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  wire                      req_command,
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   output logic                     rsp_tlast,
   input  lsbp_pkg::dp_status_type  status,
   output lsbp_pkg::dp_cmd_type     cmd
);
   import lsbp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // Next state and datapath commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_command == CMD_FLUSH) begin
                  if (!status.fill_zero) begin
                     cmd.load_flush = 1'b1;
                     state_in       = ST_EMIT;
                  end
               end else begin
                  cmd.load_write = 1'b1;
                  if (status.write_has_bytes) begin
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.shift_byte = 1'b1;
               if (status.last_byte) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tlast = status.last_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : lsbp_ctrl

`default_nettype wire

/* design/lsb_first_bit_packer.sv */
// ---------------------------------------------------------------------------
// lsb_first_bit_packer: LSB-first bit packer for DEFLATE-style output
// Appends variable-length codes least significant bit first and emits each
// completed byte; a flush item emits the held partial byte.
// ---------------------------------------------------------------------------
// The first byte of an item is offered in the cycle after the item is
// accepted. Bytes leave at one per cycle, while rsp_tready is high, from the
// accumulator shift register; an item yields 0 to 4 bytes.
// Reset clears the partial byte, the fill count and the controller state.
`default_nettype none

module lsb_first_bit_packer #(
   parameter int MAX_CODE_BITS = 32
) (
   input  wire         clock,
   input  wire         reset,
   // Request channel.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // [31:0] code_value, [37:32] bit_count, [39:38] zero
   input  wire         req_tuser,   // [0] command
   // Result channel.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast    // last_of_run
);
   import lsbp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencing of items and bytes.
   lsbp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tlast   (rsp_tlast),
      .status      (status),
      .cmd         (cmd)
   );

   // Accumulator and byte output.
   lsbp_datapath #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .code_value (req_tdata[CODE_BITS-1:0]),
      .bit_count  (req_tdata[CODE_BITS+COUNT_BITS-1:CODE_BITS]),
      .out_byte   (rsp_tdata)
   );

endmodule : lsb_first_bit_packer

`default_nettype wire
